### hw/rtl/ihd_pkg.sv
// Shared constants and codes for the inverse hyperbolic block.
package ihd_pkg;

    // Fraction bits of the log2 mantissa and of ln2.
    localparam int LG_FRAC = 30;
    localparam int LN2_FRAC = 24;
    localparam logic [LN2_FRAC-1:0] LN2_Q24 = 24'd11629080;

    typedef enum logic {
        CMD_ASINH = 1'b0,
        CMD_ACOSH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DOMAIN = 2'd1,
        ST_SAT    = 2'd2
    } status_t;

endpackage

### hw/rtl/ihd_if.sv
// Valid/ready channel interfaces for operands and results.
interface ihd_in_if #(
    parameter int IN_WIDTH = 32
);
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [IN_WIDTH-1:0] x_value;

    modport source (output valid, cmd, x_value, input ready);
    modport sink   (input valid, cmd, x_value, output ready);
endinterface

interface ihd_out_if #(
    parameter int FRAC_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+4:0] func_value;
    logic [FRAC_BITS+7:0]        slope_value;
    logic [1:0]                  status;

    modport source (output valid, func_value, slope_value, status, input ready);
    modport sink   (input valid, func_value, slope_value, status, output ready);
endinterface

### hw/rtl/ihd_sqrt_cell.sv
// One bit of a pipelined restoring square root.
module ihd_sqrt_cell #(
    parameter int IN_WIDTH = 32,
    parameter int SIDE_W   = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [IN_WIDTH+1:0]   rem_in,
    input  logic [IN_WIDTH-1:0]   root_in,
    input  logic [2*IN_WIDTH-1:0] rad_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  valid_out,
    output logic [IN_WIDTH+1:0]   rem_out,
    output logic [IN_WIDTH-1:0]   root_out,
    output logic [2*IN_WIDTH-1:0] rad_out,
    output logic [SIDE_W-1:0]     side_out
);
    logic                  valid_reg;
    logic [IN_WIDTH+1:0]   rem_reg;
    logic [IN_WIDTH+1:0]   rem_next;
    logic [IN_WIDTH-1:0]   root_reg;
    logic [2*IN_WIDTH-1:0] rad_reg;
    logic [SIDE_W-1:0]     side_reg;
    logic [IN_WIDTH+1:0]   partial;
    logic [IN_WIDTH+1:0]   trial;
    logic                  fits;

    always_comb
    begin
        partial  = {rem_in[IN_WIDTH-1:0], rad_in[2*IN_WIDTH-1 -: 2]};
        trial    = {root_in, 2'b01};
        fits     = (partial >= trial);
        rem_next = fits ? (partial - trial) : partial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= {root_in[IN_WIDTH-2:0], fits};
            rad_reg  <= {rad_in[2*IN_WIDTH-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rad_out   = rad_reg;
    assign side_out  = side_reg;
endmodule

### hw/rtl/ihd_div_cell.sv
// One quotient bit of a pipelined restoring divider.
module ihd_div_cell #(
    parameter int IN_WIDTH  = 32,
    parameter int QUO_W     = 33,
    parameter int SIDE_W    = 1,
    parameter bit FIRST_BIT = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  logic [IN_WIDTH:0]   rem_in,
    input  logic [IN_WIDTH-1:0] den_in,
    input  logic [QUO_W-1:0]    quo_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [IN_WIDTH:0]   rem_out,
    output logic [IN_WIDTH-1:0] den_out,
    output logic [QUO_W-1:0]    quo_out,
    output logic [SIDE_W-1:0]   side_out
);
    logic                valid_reg;
    logic [IN_WIDTH:0]   rem_reg;
    logic [IN_WIDTH:0]   rem_next;
    logic [IN_WIDTH-1:0] den_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic [IN_WIDTH:0]   partial;
    logic                fits;

    // dividend is a single one bit, at the top position
    always_comb
    begin
        partial  = {rem_in[IN_WIDTH-1:0], FIRST_BIT};
        fits     = (partial >= {1'b0, den_in});
        rem_next = fits ? (partial - {1'b0, den_in}) : partial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= {quo_in[QUO_W-2:0], fits};
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;
endmodule

### hw/rtl/ihd_log_cell.sv
// One fraction bit of log2 by mantissa squaring.
module ihd_log_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [ihd_pkg::LG_FRAC:0]   mant_in,
    input  logic [ihd_pkg::LG_FRAC-1:0] frac_in,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        valid_out,
    output logic [ihd_pkg::LG_FRAC:0]   mant_out,
    output logic [ihd_pkg::LG_FRAC-1:0] frac_out,
    output logic [SIDE_W-1:0]           side_out
);
    import ihd_pkg::*;

    logic                      valid_reg;
    logic [LG_FRAC:0]          mant_reg;
    logic [LG_FRAC:0]          mant_next;
    logic [LG_FRAC-1:0]        frac_reg;
    logic [SIDE_W-1:0]         side_reg;
    logic [2*LG_FRAC+1:0]      square;
    logic [LG_FRAC+1:0]        scaled;

    always_comb
    begin
        square    = (2*LG_FRAC+2)'(mant_in) * (2*LG_FRAC+2)'(mant_in);
        scaled    = square[2*LG_FRAC+1:LG_FRAC];
        mant_next = scaled[LG_FRAC+1] ? scaled[LG_FRAC+1:1] : scaled[LG_FRAC:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_reg <= mant_next;
            frac_reg <= {frac_in[LG_FRAC-2:0], scaled[LG_FRAC+1]};
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign mant_out  = mant_reg;
    assign frac_out  = frac_reg;
    assign side_out  = side_reg;
endmodule

### hw/rtl/inverse_hyperbolic_with_derivative.sv
// Top level: asinh/acosh with derivative, a chain of bit cells.
//
//  channel  dir  payload                               transaction when
//  in_ch    in   cmd, x_value (Q.FRAC_BITS signed)     valid && ready
//  out_ch   out  func_value, slope_value, status       valid && ready
//
// Throughput: one transaction per cycle while the output is not stalled. The
// chain is made of the front stage, the square root row (one cell per root
// bit), the divider row (one cell per quotient bit), the normalize stage, the
// log2 row (one cell per fraction bit) and the output register.
// Reset clears only the valid bits of the stages and the output register.
// The whole chain advances together whenever the output register is empty or
// being read; a stalled output freezes every stage, bubbles included.
module inverse_hyperbolic_with_derivative #(
    parameter int FRAC_BITS = 16,
    parameter int IN_WIDTH  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ihd_in_if.sink    in_ch,
    ihd_out_if.source out_ch
);
    import ihd_pkg::*;

    localparam int VAL_W   = FRAC_BITS + 5;
    localparam int SLOPE_W = FRAC_BITS + 8;
    localparam int QUO_W   = 2 * FRAC_BITS + 1;
    localparam int U_W     = IN_WIDTH + 1;
    localparam int P_W     = $clog2(U_W);
    localparam int EXT_W   = U_W + LG_FRAC;
    localparam int LG_W    = P_W + LG_FRAC;
    localparam int PROD_W  = LG_W + LN2_FRAC;
    localparam int RSH     = LG_FRAC + LN2_FRAC - FRAC_BITS;
    localparam int SQ_SW   = 2 + IN_WIDTH;
    localparam int DV_SW   = 2 + U_W;
    localparam int LG_SW   = 3 + P_W + SLOPE_W;

    localparam logic [IN_WIDTH-1:0]   ONE_T    = IN_WIDTH'(1) << FRAC_BITS;
    localparam logic [2*IN_WIDTH-1:0] ONE_SQ   = (2*IN_WIDTH)'(1) << (2*FRAC_BITS);
    localparam logic [QUO_W-1:0]      SLOPE_MX = QUO_W'({SLOPE_W{1'b1}});
    localparam logic [VAL_W-1:0]      MAG_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [PROD_W-1:0]     HALF     = PROD_W'(1) << (RSH - 1);

    // global advance: output register empty or being drained
    logic en;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- front: magnitude, domain check, square ----------------
    logic                  f_valid_reg;
    logic                  f_cmd_reg;
    logic                  f_neg_reg;
    logic                  f_dom_reg;
    logic [IN_WIDTH-1:0]   f_t_reg;
    logic [2*IN_WIDTH-1:0] f_sq_reg;
    logic                  x_neg;
    logic [IN_WIDTH-1:0]   x_mag;
    logic                  x_dom;

    always_comb
    begin
        x_neg = in_ch.x_value[IN_WIDTH-1];
        x_mag = x_neg ? (~in_ch.x_value + IN_WIDTH'(1)) : in_ch.x_value;
        // acosh needs x >= 1
        x_dom = (in_ch.cmd == CMD_ACOSH) && (x_neg || (x_mag < ONE_T));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_cmd_reg <= in_ch.cmd;
            f_neg_reg <= x_neg;
            f_dom_reg <= x_dom;
            f_t_reg   <= x_mag;
            f_sq_reg  <= (2*IN_WIDTH)'(x_mag) * (2*IN_WIDTH)'(x_mag);
        end
    end

    // ---------------- square root row: s = floor(sqrt(t*t +/- 1)) ----------------
    logic                  sq_valid [0:IN_WIDTH];
    logic [IN_WIDTH+1:0]   sq_rem   [0:IN_WIDTH];
    logic [IN_WIDTH-1:0]   sq_root  [0:IN_WIDTH];
    logic [2*IN_WIDTH-1:0] sq_rad   [0:IN_WIDTH];
    logic [SQ_SW-1:0]      sq_side  [0:IN_WIDTH];

    assign sq_valid[0] = f_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = (f_cmd_reg == CMD_ACOSH) ? (f_sq_reg - ONE_SQ) : (f_sq_reg + ONE_SQ);
    assign sq_side[0]  = {f_neg_reg, f_dom_reg, f_t_reg};

    for (genvar k = 0; k < IN_WIDTH; k++)
    begin : g_sqrt
        ihd_sqrt_cell #(
            .IN_WIDTH (IN_WIDTH),
            .SIDE_W   (SQ_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .rad_in    (sq_rad[k]),
            .side_in   (sq_side[k]),
            .valid_out (sq_valid[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .rad_out   (sq_rad[k+1]),
            .side_out  (sq_side[k+1])
        );
    end

    // ---------------- divider row: slope = 2^(2F) / s ----------------
    logic                sq_neg;
    logic                sq_dom;
    logic [IN_WIDTH-1:0] sq_t;
    logic [U_W-1:0]      sum_u;

    assign {sq_neg, sq_dom, sq_t} = sq_side[IN_WIDTH];
    assign sum_u = U_W'(sq_t) + U_W'(sq_root[IN_WIDTH]);

    logic                dv_valid [0:QUO_W];
    logic [IN_WIDTH:0]   dv_rem   [0:QUO_W];
    logic [IN_WIDTH-1:0] dv_den   [0:QUO_W];
    logic [QUO_W-1:0]    dv_quo   [0:QUO_W];
    logic [DV_SW-1:0]    dv_side  [0:QUO_W];

    assign dv_valid[0] = sq_valid[IN_WIDTH];
    assign dv_rem[0]   = '0;
    assign dv_den[0]   = sq_root[IN_WIDTH];
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = {sq_neg, sq_dom, sum_u};

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        ihd_div_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .QUO_W     (QUO_W),
            .SIDE_W    (DV_SW),
            .FIRST_BIT (j == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[j]),
            .rem_in    (dv_rem[j]),
            .den_in    (dv_den[j]),
            .quo_in    (dv_quo[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_valid[j+1]),
            .rem_out   (dv_rem[j+1]),
            .den_out   (dv_den[j+1]),
            .quo_out   (dv_quo[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    // ---------------- normalize u, finish slope ----------------
    logic                 dv_neg;
    logic                 dv_dom;
    logic [U_W-1:0]       dv_u;
    logic [P_W-1:0]       lead;
    logic [EXT_W-1:0]     ext;
    logic                 slope_sat;
    logic [SLOPE_W-1:0]   slope_c;

    assign {dv_neg, dv_dom, dv_u} = dv_side[QUO_W];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < U_W; i++)
        begin
            if (dv_u[i])
            begin
                lead = P_W'(i);
            end
        end
        // mantissa in [1,2) with LG_FRAC fraction bits, truncated
        ext = (EXT_W'(dv_u) << LG_FRAC) >> lead;
        // zero root (acosh of exactly one) or oversized quotient
        slope_sat = (dv_den[QUO_W] == '0) || (dv_quo[QUO_W] > SLOPE_MX);
        slope_c   = slope_sat ? {SLOPE_W{1'b1}} : dv_quo[QUO_W][SLOPE_W-1:0];
    end

    logic                 n_valid_reg;
    logic [LG_SW-1:0]     n_side_reg;
    logic [LG_FRAC:0]     n_mant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n_valid_reg <= dv_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_mant_reg <= ext[LG_FRAC:0];
            n_side_reg <= {dv_neg, dv_dom, lead - P_W'(FRAC_BITS), slope_c, slope_sat};
        end
    end

    // ---------------- log2 row: one fraction bit per cell ----------------
    logic               lg_valid [0:LG_FRAC];
    logic [LG_FRAC:0]   lg_mant  [0:LG_FRAC];
    logic [LG_FRAC-1:0] lg_frac  [0:LG_FRAC];
    logic [LG_SW-1:0]   lg_side  [0:LG_FRAC];

    assign lg_valid[0] = n_valid_reg;
    assign lg_mant[0]  = n_mant_reg;
    assign lg_frac[0]  = '0;
    assign lg_side[0]  = n_side_reg;

    for (genvar b = 0; b < LG_FRAC; b++)
    begin : g_log
        ihd_log_cell #(
            .SIDE_W (LG_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (lg_valid[b]),
            .mant_in   (lg_mant[b]),
            .frac_in   (lg_frac[b]),
            .side_in   (lg_side[b]),
            .valid_out (lg_valid[b+1]),
            .mant_out  (lg_mant[b+1]),
            .frac_out  (lg_frac[b+1]),
            .side_out  (lg_side[b+1])
        );
    end

    // ---------------- ln scaling, sign, output register ----------------
    logic               o_neg;
    logic               o_dom;
    logic [P_W-1:0]     o_exp;
    logic [SLOPE_W-1:0] o_slope;
    logic               o_sat;
    logic [PROD_W-1:0]  ln_prod;
    logic [PROD_W-1:0]  ln_round;
    logic [VAL_W-1:0]   mag;
    logic [VAL_W-1:0]   func_c;

    assign {o_neg, o_dom, o_exp, o_slope, o_sat} = lg_side[LG_FRAC];

    always_comb
    begin
        ln_prod  = PROD_W'({o_exp, lg_frac[LG_FRAC]}) * PROD_W'(LN2_Q24);
        ln_round = (ln_prod + HALF) >> RSH;
        mag      = (ln_round > PROD_W'(MAG_MAX)) ? MAG_MAX : ln_round[VAL_W-1:0];
        func_c   = o_neg ? (~mag + VAL_W'(1)) : mag;
    end

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_func_reg;
    logic [SLOPE_W-1:0] out_slope_reg;
    status_t            out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lg_valid[LG_FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (o_dom)
            begin
                out_func_reg   <= '0;
                out_slope_reg  <= '0;
                out_status_reg <= ST_DOMAIN;
            end
            else
            begin
                out_func_reg   <= func_c;
                out_slope_reg  <= o_slope;
                out_status_reg <= o_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.func_value  = out_func_reg;
    assign out_ch.slope_value = out_slope_reg;
    assign out_ch.status      = out_status_reg;

    // ---------------- checks ----------------
    a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_DOMAIN)
            |-> (out_ch.func_value == '0 && out_ch.slope_value == '0))
        else $error("domain error result not zeroed");

    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_SAT) |-> (&out_ch.slope_value))
        else $error("saturated slope not at maximum");

    a_front_to_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_ch.valid) |=> f_valid_reg)
        else $error("accepted transaction lost at front stage");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (n_valid_reg == $past(n_valid_reg)))
        else $error("chain moved during stall");
endmodule
